/* rtl/core/sb5_pkg.sv */
// shared types, constants and filter functions for the separable 5-tap blur
package sb5_pkg;

  // frame geometry
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int LINE_COUNT        = 4;
  localparam int SLOT_W            = $clog2(LINE_COUNT);
  localparam int MIN_DIM           = 5;
  localparam int MAX_HEIGHT        = 4096;
  localparam int ROW_W             = 12;
  localparam int HEIGHT_W          = 13;
  localparam int WIDTH_REG_W       = 11;
  localparam int CFG_DATA_W        = 13;

  // pixel packing: blue in the low byte, red in the high byte
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int LINE_W = LINE_COUNT * PIX_W;

  // tap sum is at most 10 * 255, divide by 10 through a reciprocal
  localparam int SUM_W       = 12;
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W      = 28;

  // output queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic              frame_end;
  } result_t;

  // horizontal result on its way to the line store
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [PIX_W-1:0]  hv;
  } stage_t;

  // truncating divide by 10, exact over the tap sum range
  function automatic logic [CHAN_W-1:0] div10(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV10_MUL);
    return p[DIV10_SHIFT +: CHAN_W];
  endfunction

  // taps 1,2,4,2,1 per channel over five packed pixels
  function automatic logic [PIX_W-1:0] tap5(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] m,
                                            input logic [PIX_W-1:0] d,
                                            input logic [PIX_W-1:0] e);
    logic [PIX_W-1:0] res;
    logic [SUM_W-1:0] s;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      s = SUM_W'(a[CHAN_W*k +: CHAN_W])
        + SUM_W'({b[CHAN_W*k +: CHAN_W], 1'b0})
        + SUM_W'({m[CHAN_W*k +: CHAN_W], 2'b00})
        + SUM_W'({d[CHAN_W*k +: CHAN_W], 1'b0})
        + SUM_W'(e[CHAN_W*k +: CHAN_W]);
      res[CHAN_W*k +: CHAN_W] = div10(s);
    end
    return res;
  endfunction

endpackage

/* rtl/core/sb5_hpass.sv */
// position counters, row window and horizontal pass
module sb5_hpass import sb5_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  pixel_t              pixel,
  input  logic [WW-1:0]       eff_width,
  input  logic [HEIGHT_W-1:0] eff_height,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output stage_t              stage,
  output logic [AW-1:0]       stage_addr
);

  logic [AW-1:0]       col;
  logic [ROW_W-1:0]    row;
  logic [PIX_W-1:0]    win [4];
  logic [PIX_W-1:0]    cur;
  logic [WW-1:0]       col_w;
  logic [WW-1:0]       col_inc;
  logic [HEIGHT_W-1:0] row_h;
  logic [HEIGHT_W-1:0] row_inc;
  logic                compute;
  stage_t              stage_next;

  assign cur     = {pixel.red_in, pixel.green_in, pixel.blue_in};
  assign col_w   = WW'(col);
  assign col_inc = col_w + WW'(1);
  assign row_h   = HEIGHT_W'(row);
  assign row_inc = row_h + HEIGHT_W'(1);

  // a full five-pixel window inside the current row
  assign compute = (col >= AW'(4)) && (col_w < eff_width);
  assign rd_en   = accept && compute;
  assign rd_addr = col - AW'(2);

  // next stage contents
  always_comb begin
    stage_next.valid = rd_en;
    stage_next.emit  = (row >= ROW_W'(4)) && (row_h < eff_height);
    stage_next.last  = (row_h == eff_height - HEIGHT_W'(1))
                    && (col_w == eff_width - WW'(1));
    stage_next.slot  = row[SLOT_W-1:0];
    stage_next.hv    = tap5(win[0], win[1], win[2], win[3], cur);
  end

  // position counters and window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      for (int k = 0; k < 4; k++) begin
        win[k] <= '0;
      end
    end else if (accept) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= cur;
      if (col_inc >= eff_width) begin
        col <= '0;
        row <= (row_inc >= eff_height) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[AW-1:0];
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
    stage.emit <= stage_next.emit;
    stage.last <= stage_next.last;
    stage.slot <= stage_next.slot;
    stage.hv   <= stage_next.hv;
    stage_addr <= rd_addr;
  end

endmodule

/* rtl/core/sb5_vpass.sv */
// line store with per-column read-modify-write and vertical pass
module sb5_vpass import sb5_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  stage_t        stage,
  input  logic [AW-1:0] wr_addr,
  output logic          push,
  output result_t       push_data
);

  // one word per column holds all four line slots
  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] word;
  logic [LINE_W-1:0] wr_word;
  logic [PIX_W-1:0]  lines [LINE_COUNT];
  logic [PIX_W-1:0]  v;
  logic [SLOT_W-1:0] sk;

  always_ff @(posedge clk) begin
    if (stage.valid) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      word <= mem[rd_addr];
    end
  end

  // oldest line sits in the slot of the current row
  always_comb begin
    sk = '0;
    for (int k = 0; k < LINE_COUNT; k++) begin
      sk = stage.slot + SLOT_W'(k);
      lines[k] = word[PIX_W*sk +: PIX_W];
      wr_word[PIX_W*k +: PIX_W] = (SLOT_W'(k) == stage.slot) ? stage.hv
                                                             : word[PIX_W*k +: PIX_W];
    end
  end

  // vertical taps and result
  assign v                   = tap5(lines[0], lines[1], lines[2], lines[3], stage.hv);
  assign push                = stage.valid && stage.emit;
  assign push_data.blue_out  = v[0 +: CHAN_W];
  assign push_data.green_out = v[CHAN_W +: CHAN_W];
  assign push_data.red_out   = v[2*CHAN_W +: CHAN_W];
  assign push_data.frame_end = stage.last;

  // write-back goes to the column read in the previous cycle
  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    stage.valid |-> $past(rd_en) && (wr_addr == $past(rd_addr)))
    else $error("line store write-back address does not match its read");

  // a new read never hits the column being written back
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    stage.valid && rd_en |-> wr_addr != rd_addr)
    else $error("line store read and write-back hit the same column");

endmodule

/* rtl/core/sb5_outq.sv */
// small result queue decoupling the pipeline from the output stall
module sb5_outq import sb5_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_data,
  output logic             valid,
  input  logic             stall,
  output result_t          data,
  output logic [OQ_CW-1:0] count
);

  result_t          entries [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_ptr;
  logic [OQ_PW-1:0] rd_ptr;
  logic             pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OQ_PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr + OQ_PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OQ_PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr + OQ_PW'(1);
      end
      count <= count + OQ_CW'(push) - OQ_CW'(pop);
    end
  end

endmodule

/* rtl/core/separable_blur_5tap.sv */
// Separable 5x5 blur (taps 1,2,4,2,1, divide by 10) on a raster pixel stream.
// Throughput: one pixel per cycle unless stalled, set by one read-modify-write
// of one line-store word per column per pixel. The pixel two rows below and
// two columns right sends a result through the stage register and queue.
// Reset: counters, row window and queue cleared, registers to 640 x 480; the
// line store is not cleared, the first four rows of a frame fill it.
module separable_blur_5tap import sb5_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  logic [WIDTH_REG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic [HEIGHT_W-1:0]    width_clamp;
  logic [HEIGHT_W-1:0]    height_clamp;
  logic [WW-1:0]          eff_width;
  logic                   accept;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  stage_t                 stage;
  logic [AW-1:0]          stage_addr;
  logic                   push;
  result_t                push_data;
  logic [OQ_CW-1:0]       q_count;
  logic [OQ_CW:0]         occupancy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(640);
      image_height <= HEIGHT_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    width_clamp = HEIGHT_W'(image_width);
    if (width_clamp < HEIGHT_W'(MIN_DIM)) begin
      width_clamp = HEIGHT_W'(MIN_DIM);
    end else if (width_clamp > HEIGHT_W'(MAX_WIDTH)) begin
      width_clamp = HEIGHT_W'(MAX_WIDTH);
    end
    height_clamp = image_height;
    if (height_clamp < HEIGHT_W'(MIN_DIM)) begin
      height_clamp = HEIGHT_W'(MIN_DIM);
    end else if (height_clamp > HEIGHT_W'(MAX_HEIGHT)) begin
      height_clamp = HEIGHT_W'(MAX_HEIGHT);
    end
  end
  assign eff_width = width_clamp[WW-1:0];

  // stall while queue plus the result in flight could fill the queue
  assign occupancy   = {1'b0, q_count} + (OQ_CW + 1)'(stage.emit);
  assign pixel_stall = occupancy >= (OQ_CW + 1)'(OQ_DEPTH);
  assign accept      = pixel_valid && !pixel_stall;

  sb5_hpass #(.MAX_WIDTH(MAX_WIDTH)) u_hpass (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel      (pixel),
    .eff_width  (eff_width),
    .eff_height (height_clamp),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .stage      (stage),
    .stage_addr (stage_addr)
  );

  sb5_vpass #(.MAX_WIDTH(MAX_WIDTH)) u_vpass (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .stage     (stage),
    .wr_addr   (stage_addr),
    .push      (push),
    .push_data (push_data)
  );

  sb5_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (result),
    .count     (q_count)
  );

  // the stage only fills from an input transaction
  a_stage_src: assert property (@(posedge clk) disable iff (rst)
    stage.valid |-> $past(pixel_valid && !pixel_stall))
    else $error("pipeline stage filled without an input transaction");

  // the stall keeps room for every result in flight
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (q_count == OQ_CW'(OQ_DEPTH)) && result_stall))
    else $error("result queue overflow");

endmodule
